[design/xml_token_structure_checker_top_defines.svh]
// assertion macros for the xml token structure checker
`ifndef XML_TOKEN_STRUCTURE_CHECKER_TOP_DEFINES_SVH
`define XML_TOKEN_STRUCTURE_CHECKER_TOP_DEFINES_SVH

// checked only out of reset
`define XTSC_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("xtsc assertion failed");

// checked in reset as well
`define XTSC_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("xtsc assertion failed during reset");

`endif

[design/xtsc_pkg.sv]
// types and codes shared by the xml token structure checker files
`timescale 1ns / 1ps

package xtsc_pkg;

    typedef enum logic [2:0] {
        TK_AOPEN  = 3'd0,
        TK_ACLOSE = 3'd1,
        TK_SLASH  = 3'd2,
        TK_QUEST  = 3'd3,
        TK_DATA   = 3'd4,
        TK_QDATA  = 3'd5,
        TK_EQ     = 3'd6
    } token_kind_t;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_DECL    = 3'd1,
        EV_TOPEN   = 3'd2,
        EV_TCLOSE  = 3'd3,
        EV_CONTENT = 3'd4,
        EV_APPEND  = 3'd5,
        EV_EQ      = 3'd6
    } event_kind_t;

    typedef enum logic [2:0] {
        ERR_OK          = 3'd0,
        ERR_BAD_BEGIN   = 3'd1,
        ERR_BAD_END     = 3'd2,
        ERR_OPEN_ANGLE  = 3'd3,
        ERR_CLOSE_ANGLE = 3'd4,
        ERR_SLASH       = 3'd5,
        ERR_EQ_NO_ELEM  = 3'd6
    } error_code_t;

    typedef enum logic [3:0] {
        S_NONE     = 4'd0,
        S_TINIT    = 4'd1,
        S_TOPARSE  = 4'd2,
        S_TODONE   = 4'd3,
        S_TCPARSE  = 4'd4,
        S_TCNAMED  = 4'd5,
        S_TCDONE   = 4'd6,
        S_CONTENT  = 4'd7,
        S_DPARSE   = 4'd8,
        S_DCLOSING = 4'd9,
        S_DCLOSED  = 4'd10
    } parse_state_t;

endpackage

[design/xml_token_structure_checker_top.sv]
// xml token structure checker: structure state machine and registered result
`timescale 1ns / 1ps

// Takes one lexed XML token per transaction and returns one result transaction per token,
// in the cycle after the token is accepted: an event (declaration, tag open, tag close,
// content, append data or append equals) with the token's data handle, or the first
// structural error of the document. A token is accepted every cycle the result register is
// empty or being taken, so the block sustains one token per clock; latency and rate are set
// by the single result register after the state decode. After an error the remaining
// tokens of that document give empty results, and the token marked last always returns the
// structure state to its reset value.
module xml_token_structure_checker_top
    import xtsc_pkg::*;
#(
    parameter int REF_WIDTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           token_kind,
    input  logic [REF_WIDTH-1:0] data_ref,
    input  logic                 is_last,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           event_kind,
    output logic [REF_WIDTH-1:0] event_ref,
    output logic [2:0]           error_code,
    output logic                 document_done
);

    parse_state_t         state_reg, state_next, st_step;
    logic                 at_start_reg, at_start_next;
    logic                 failed_reg, failed_next;
    logic                 elem_reg, elem_next;
    logic                 out_valid_reg, out_valid_next;
    event_kind_t          ev_reg, ev, ev_out;
    logic [REF_WIDTH-1:0] ref_reg, ref_out;
    error_code_t          err_reg, err, err_out;
    logic                 done_reg;
    logic                 accept;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // structure transition and error check
    always_comb
    begin
        st_step = state_reg;
        err     = ERR_OK;
        priority if (at_start_reg && token_kind != TK_AOPEN)
        begin
            err = ERR_BAD_BEGIN;
        end
        else if (is_last && token_kind != TK_ACLOSE)
        begin
            err = ERR_BAD_END;
        end
        else
        begin
            unique case (token_kind)
                TK_AOPEN:
                begin
                    if (state_reg == S_TINIT || state_reg == S_TOPARSE)
                        err = ERR_OPEN_ANGLE;
                    else
                        st_step = S_TINIT;
                end
                TK_ACLOSE:
                begin
                    priority if (state_reg == S_TOPARSE)
                        st_step = S_TODONE;
                    else if (state_reg == S_TCNAMED)
                        st_step = S_TCDONE;
                    else if (state_reg == S_DCLOSING)
                        st_step = S_DCLOSED;
                    else
                        err = ERR_CLOSE_ANGLE;
                end
                TK_SLASH:
                begin
                    if (state_reg == S_TINIT || state_reg == S_CONTENT)
                        st_step = S_TCPARSE;
                    else
                        err = ERR_SLASH;
                end
                TK_QUEST:
                begin
                    if (state_reg == S_TINIT)
                        st_step = S_DPARSE;
                    else if (state_reg == S_DPARSE)
                        st_step = S_DCLOSING;
                end
                TK_DATA, TK_QDATA:
                begin
                    // data in any other state leaves the structure alone
                    if (state_reg == S_TINIT)
                        st_step = S_TOPARSE;
                    else if (state_reg == S_TCPARSE)
                        st_step = S_TCNAMED;
                    else if (state_reg == S_TCDONE || state_reg == S_TODONE)
                        st_step = S_CONTENT;
                end
                TK_EQ:
                begin
                    if (!elem_reg)
                        err = ERR_EQ_NO_ELEM;
                end
                default:
                begin
                    st_step = state_reg;
                end
            endcase
        end
    end

    // event for the token, before error masking
    always_comb
    begin
        ev = EV_NONE;
        unique case (token_kind)
            TK_QUEST:
            begin
                if (state_reg == S_TINIT)
                    ev = EV_DECL;
            end
            TK_DATA, TK_QDATA:
            begin
                if (state_reg == S_TINIT)
                    ev = EV_TOPEN;
                else if (state_reg == S_TCPARSE)
                    ev = EV_TCLOSE;
                else if (state_reg == S_TCDONE || state_reg == S_TODONE)
                    ev = EV_CONTENT;
                else if (state_reg == S_DPARSE)
                    ev = EV_APPEND;
            end
            TK_EQ:
            begin
                if (elem_reg)
                    ev = EV_EQ;
            end
            default:
            begin
                ev = EV_NONE;
            end
        endcase
    end

    // result and state update for an accepted token
    always_comb
    begin
        ev_out        = EV_NONE;
        ref_out       = '0;
        err_out       = ERR_OK;
        state_next    = state_reg;
        at_start_next = at_start_reg;
        failed_next   = failed_reg;
        elem_next     = elem_reg;
        if (!failed_reg)
        begin
            if (err != ERR_OK)
            begin
                err_out     = err;
                failed_next = 1'b1;
            end
            else
            begin
                ev_out     = ev;
                state_next = st_step;
                if (ev == EV_TOPEN || ev == EV_TCLOSE || ev == EV_CONTENT || ev == EV_APPEND)
                    ref_out = data_ref;
                if (ev == EV_DECL || ev == EV_TOPEN || ev == EV_TCLOSE || ev == EV_CONTENT)
                    elem_next = 1'b1;
            end
        end
        at_start_next = 1'b0;
        // end of document: back to the reset state whatever happened
        if (is_last)
        begin
            state_next    = S_NONE;
            at_start_next = 1'b1;
            failed_next   = 1'b0;
            elem_next     = 1'b0;
        end
    end

    assign out_valid_next = accept || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_NONE;
            at_start_reg  <= 1'b1;
            failed_reg    <= 1'b0;
            elem_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                state_reg    <= state_next;
                at_start_reg <= at_start_next;
                failed_reg   <= failed_next;
                elem_reg     <= elem_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ev_reg   <= ev_out;
            ref_reg  <= ref_out;
            err_reg  <= err_out;
            done_reg <= is_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign event_kind    = ev_reg;
    assign event_ref     = ref_reg;
    assign error_code    = err_reg;
    assign document_done = done_reg;

endmodule

[design/xtsc_checker.sv]
// port-level assertions for the xml token structure checker and their bind
`timescale 1ns / 1ps
`include "xml_token_structure_checker_top_defines.svh"

module xtsc_checker
    import xtsc_pkg::*;
#(
    parameter int REF_WIDTH = 16
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 is_last,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [2:0]           event_kind,
    input logic [REF_WIDTH-1:0] event_ref,
    input logic [2:0]           error_code,
    input logic                 document_done
);

    // an error result carries no event
    `XTSC_ASSERT(a_err_no_event, out_valid && error_code != ERR_OK |-> event_kind == EV_NONE && event_ref == '0)

    // handles only travel with events that name data
    `XTSC_ASSERT(a_ref_zero, out_valid && (event_kind == EV_NONE || event_kind == EV_DECL || event_kind == EV_EQ) |-> event_ref == '0)

    // every accepted token yields its result on the next cycle
    `XTSC_ASSERT(a_result_follows, in_valid && in_ready |=> out_valid && document_done == $past(is_last))

    // a stalled result holds
    `XTSC_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(event_kind) && $stable(event_ref) && $stable(error_code))

    `XTSC_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !out_valid)

endmodule

bind xml_token_structure_checker_top xtsc_checker #(.REF_WIDTH(REF_WIDTH)) u_xtsc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .is_last       (is_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_kind    (event_kind),
    .event_ref     (event_ref),
    .error_code    (error_code),
    .document_done (document_done)
);
